// ===== rtl/olad_pkg.sv =====
// Shared types and constants for the ordered list append/delete block.
package olad_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    FN_APPEND   = 2'd0,
    FN_DELETE   = 2'd1,
    FN_TRAVERSE = 2'd2,
    FN_NOP      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    func_t                     func;
    logic signed [DATA_W-1:0]  data_value;
  } cmd_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  out_value;
    logic                      last;
    logic [CNT_W-1:0]          list_count;
  } res_t;

endpackage

// ===== rtl/olad_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module olad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ordered_list_append_delete_top.sv =====
// Ordered list of signed values in one RAM: append, delete first match, traverse.
//
// Usage:
//   An item (cmd.func, cmd.data_value) is taken at a rising edge with start high
//   and busy low. Results appear on result for one cycle each, flagged by done;
//   the receiver cannot hold them off. result.last marks the final one of an item.
// Sequencing (N = entries stored):
//   Append, unused code and any empty-list case: result registered at accept,
//   busy stays low, so a new item may follow in the next cycle.
//   Traverse: N results, the first after the registered RAM read, then one
//   per cycle, streamed from the single RAM read port; busy until the last one.
//   Delete: a search streams the RAM (one entry per cycle, registered read
//   data); a miss ends it with not-found, a match starts a shift pass that moves
//   every later entry down one slot, reading one and writing one per cycle.
//   Search and shift together cover the N entries once; busy drops as done shows.
// Reset:
//   rst (synchronous) empties the list; RAM contents are not cleared, entries at
//   or above the count are never used.
// Stalls:
//   None; results are never back-pressured.
module ordered_list_append_delete_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  olad_pkg::cmd_t cmd,
  output logic          done,
  output olad_pkg::res_t result
);
  import olad_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SHIFT, S_TRAV} state_t;

  state_t                   state;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         idx;
  logic [IDX_W-1:0]         pidx;
  logic                     pend;
  logic signed [DATA_W-1:0] val;

  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [DATA_W-1:0]        wdata;
  logic [IDX_W-1:0]         raddr;
  logic [DATA_W-1:0]        rdata;

  logic [CNT_W-1:0]         last_idx;
  logic                     full;
  logic                     empty;
  logic                     at_last;
  logic                     more;

  assign busy     = (state != S_IDLE);
  assign last_idx = cnt - CNT_W'(1);
  assign full     = (cnt == CNT_W'(LIST_DEPTH));
  assign empty    = (cnt == '0);
  assign at_last  = (CNT_W'(pidx) == last_idx);
  assign more     = (idx < cnt);

  olad_ram #(
    .WIDTH(DATA_W),
    .DEPTH(LIST_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = pidx - IDX_W'(1);
    wdata = rdata;
    raddr = idx[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (start && cmd.func == FN_APPEND && !full) begin
          we    = 1'b1;
          waddr = cnt[IDX_W-1:0];
          wdata = cmd.data_value;
        end
      end
      S_SHIFT: we = pend;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            val  <= cmd.data_value;
            idx  <= '0;
            pend <= 1'b0;
            result.out_value <= '0;
            result.last      <= 1'b1;
            unique case (cmd.func)
              FN_APPEND: begin
                done <= 1'b1;
                if (full) begin
                  result.status     <= ST_FULL;
                  result.list_count <= cnt;
                end else begin
                  cnt               <= cnt + CNT_W'(1);
                  result.status     <= ST_OK;
                  result.list_count <= cnt + CNT_W'(1);
                end
              end
              FN_DELETE, FN_TRAVERSE: begin
                result.list_count <= cnt;
                if (empty) begin
                  done          <= 1'b1;
                  result.status <= ST_EMPTY;
                end else begin
                  state <= (cmd.func == FN_DELETE) ? S_SEARCH : S_TRAV;
                end
              end
              default: begin
                done              <= 1'b1;
                result.status     <= ST_OK;
                result.list_count <= cnt;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (pend && rdata == val) begin
            state <= S_SHIFT;
            idx   <= CNT_W'(pidx) + CNT_W'(1);
            pend  <= 1'b0;
          end else if (pend && at_last) begin
            state             <= S_IDLE;
            pend              <= 1'b0;
            done              <= 1'b1;
            result.status     <= ST_NOTFOUND;
            result.out_value  <= '0;
            result.last       <= 1'b1;
            result.list_count <= cnt;
          end else begin
            pend <= more;
            pidx <= idx[IDX_W-1:0];
            if (more) begin
              idx <= idx + CNT_W'(1);
            end
          end
        end
        S_SHIFT: begin
          if (!pend && !more) begin
            state             <= S_IDLE;
            cnt               <= last_idx;
            done              <= 1'b1;
            result.status     <= ST_OK;
            result.out_value  <= '0;
            result.last       <= 1'b1;
            result.list_count <= last_idx;
          end else begin
            pend <= more;
            pidx <= idx[IDX_W-1:0];
            if (more) begin
              idx <= idx + CNT_W'(1);
            end
          end
        end
        S_TRAV: begin
          if (pend) begin
            done              <= 1'b1;
            result.status     <= ST_OK;
            result.out_value  <= signed'(rdata);
            result.last       <= at_last;
            result.list_count <= cnt;
          end
          if (pend && at_last) begin
            state <= S_IDLE;
            pend  <= 1'b0;
          end else begin
            pend <= more;
            pidx <= idx[IDX_W-1:0];
            if (more) begin
              idx <= idx + CNT_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(LIST_DEPTH))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |-> result.list_count == CNT_W'(LIST_DEPTH))
    else $error("full status with list not full");

  a_quick_ops: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd.func == FN_APPEND || cmd.func == FN_NOP)
    |=> done && result.last)
    else $error("append result not in next cycle");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> busy && state == S_TRAV)
    else $error("non-final result outside traverse");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.last && result.out_value == '0)
    else $error("error result not single and zero");
`endif

endmodule

// ===== tb/ordered_list_append_delete_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the ordered list block: mirrors the list and checks every result on arrival.
module ordered_list_append_delete_top_tb;
  import olad_pkg::*;

  class list_mirror;
    logic signed [DATA_W-1:0] entries[$];
    res_t due_results[$];
    int errors, items, results, fulls, misses, empties, full_walks;

    function void note_cmd(cmd_t c);
      res_t r;
      int hit;
      r = '0;
      r.status = ST_OK;
      r.last = 1'b1;
      hit = -1;
      items++;
      case (c.func)
        FN_APPEND: begin
          if (entries.size() >= LIST_DEPTH) begin
            r.status = ST_FULL;
            fulls++;
          end else begin
            entries.push_back(c.data_value);
          end
        end
        FN_DELETE: begin
          foreach (entries[i]) if (hit < 0 && entries[i] == c.data_value) hit = i;
          if (entries.size() == 0) begin
            r.status = ST_EMPTY;
            empties++;
          end else if (hit < 0) begin
            r.status = ST_NOTFOUND;
            misses++;
          end else begin
            entries.delete(hit);
          end
        end
        FN_TRAVERSE: begin
          if (entries.size() == 0) begin
            r.status = ST_EMPTY;
            empties++;
          end else begin
            if (entries.size() == LIST_DEPTH) full_walks++;
            foreach (entries[i]) begin
              r.out_value = entries[i];
              r.last = (i == entries.size() - 1);
              r.list_count = CNT_W'(entries.size());
              due_results.push_back(r);
            end
            return;
          end
        end
        default: ;
      endcase
      r.list_count = CNT_W'(entries.size());
      due_results.push_back(r);
    endfunction

    function void report(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      errors++;
      if (errors <= 20)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(res_t got);
      res_t want;
      results++;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: result with none pending, expected none, actual %0h", $time, got);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.out_value !== want.out_value) report("out_value", want.out_value, got.out_value);
      if (got.last !== want.last) report("last", want.last, got.last);
      if (got.list_count !== want.list_count)
        report("list_count", want.list_count, got.list_count);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  res_t result;

  list_mirror mirror;
  int phase = 0;

  ordered_list_append_delete_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) mirror.check_result(result);
  end

  initial begin
    #2_000_000;
    $display("ordered_list_append_delete_top verification failed");
    $finish;
  end

  task automatic issue(cmd_t c);
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.note_cmd(c);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      cmd.func <= func_t'($urandom_range(0, 3));
      cmd.data_value <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int gap_len();
    case (phase)
      0: return ($urandom_range(0, 99) < 12) ? $urandom_range(1, 3) : 0;
      1: return ($urandom_range(0, 99) < 65) ? $urandom_range(1, 6) : 0;
      default: return 0;
    endcase
  endfunction

  task automatic step(func_t f, logic signed [DATA_W-1:0] v);
    cmd_t c;
    c.func = f;
    c.data_value = v;
    issue(c);
    pause(gap_len());
  endtask

  // hold off until the list has answered everything sent so far
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (mirror.due_results.size() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(bit present);
    if (present && mirror.entries.size() != 0)
      return mirror.entries[$urandom_range(0, mirror.entries.size() - 1)];
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int roll;
    bit grow;
    func_t f;
    mirror = new;
    grow = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty-list cases and the unused code
    step(FN_TRAVERSE, 32'sh1234_5678);
    step(FN_DELETE, 32'sh0);
    step(FN_NOP, -32'sd1);
    step(FN_APPEND, 32'sh8000_0000);
    step(FN_APPEND, 32'sh7fff_ffff);
    step(FN_APPEND, -32'sd1);
    step(FN_APPEND, 32'sh8000_0000);
    step(FN_DELETE, 32'sh0);
    // duplicate at head goes first, then a middle entry
    step(FN_DELETE, 32'sh8000_0000);
    step(FN_DELETE, -32'sd1);
    step(FN_TRAVERSE, 32'sh0);
    for (int i = 0; i < 14; i++)
      step(FN_APPEND, (i == 0) ? 32'sh0 : (i % 2) ? 32'shaaaa_aaaa : 32'sh5555_5555);
    step(FN_APPEND, 32'sh7);
    step(FN_TRAVERSE, 32'sh0);
    drain();

    for (int n = 0; n < 350; n++) begin
      phase = n * 3 / 350;
      if (mirror.entries.size() >= LIST_DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
      if (mirror.entries.size() == 0) grow = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 5) f = FN_NOP;
      else if (roll < 18) f = FN_TRAVERSE;
      else if (roll < (grow ? 70 : 35)) f = FN_APPEND;
      else f = FN_DELETE;
      step(f, pick_value(f == FN_DELETE && $urandom_range(0, 99) < 80));
      if (n % 70 == 69) drain();
    end

    drain();
    repeat (40) @(posedge clk);
    if (mirror.due_results.size() != 0) begin
      mirror.errors++;
      $display("%0t: %0d expected results never arrived", $time, mirror.due_results.size());
    end
    $display("Sent %0d items, checked %0d results: %0d appends on a full list,",
             mirror.items, mirror.results, mirror.fulls);
    $display("%0d deletes of absent values, %0d empty-list cases, %0d traversals of a full list.",
             mirror.misses, mirror.empties, mirror.full_walks);
    if (mirror.errors == 0) begin
      $display("ordered_list_append_delete_top verification clean");
    end else begin
      $display("ordered_list_append_delete_top verification failed");
    end
    $finish;
  end

endmodule
